[sv/vertex_transform_perspective_macros.svh]
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_MACROS_SVH

// Checked on every clock edge outside reset.
`define VTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/vtp_pkg.sv]
// Package with the constants and types of the vertex transform block.
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = PROD_W;
  localparam int NUM_LANES  = 3;
  localparam int NUM_COLS   = 4;
  localparam int NUM_ROWS   = 4;
  localparam int W_COL      = 3;
  localparam int DIV_STAGES = DATA_W;

  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 64;
  localparam int CFG_IDX_W  = 4;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(64'h1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(64'h1) << (FRAC_BITS + DATA_W);

  // Pipeline stage numbers, counted from the input side.
  localparam int ST_PROD = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_MAG  = 3;
  localparam int ST_PREP = 4;
  localparam int ST_DIV0 = 5;
  localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
  localparam int NSTG    = ST_OUT;

  localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};

  // Flags that travel alongside the divider lanes.
  typedef struct packed {
    logic                 wzero;
    logic [NUM_LANES-1:0] neg;
    logic [NUM_LANES-1:0] ovf;
  } vtp_side_t;

endpackage

[sv/vtp_div.sv]
// Pipelined restoring divider: three numerators over one shared divisor, one bit a stage.
`timescale 1ns / 1ps
`default_nettype none
module vtp_div (
  input  wire                                  clk,
  input  wire  [vtp_pkg::DIV_STAGES-1:0]       en,
  input  wire  [vtp_pkg::MAG_W-1:0]            in_wmag,
  input  wire  [vtp_pkg::MAG_W-1:0]            in_rem [vtp_pkg::NUM_LANES],
  input  wire  [vtp_pkg::DATA_W-1:0]           in_dq  [vtp_pkg::NUM_LANES],
  input  vtp_pkg::vtp_side_t                   in_side,
  output logic [vtp_pkg::DATA_W-1:0]           out_q  [vtp_pkg::NUM_LANES],
  output vtp_pkg::vtp_side_t                   out_side
);
  import vtp_pkg::*;

  logic [MAG_W-1:0]  wmag_r [1:DIV_STAGES];
  logic [MAG_W-1:0]  rem_r  [1:DIV_STAGES][NUM_LANES];
  logic [DATA_W-1:0] dq_r   [1:DIV_STAGES][NUM_LANES];
  vtp_side_t         side_r [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [MAG_W-1:0]  src_wmag;
    logic [MAG_W-1:0]  src_rem [NUM_LANES];
    logic [DATA_W-1:0] src_dq  [NUM_LANES];
    vtp_side_t         src_side;

    if (k == 0) begin : g_first
      assign src_wmag = in_wmag;
      assign src_rem  = in_rem;
      assign src_dq   = in_dq;
      assign src_side = in_side;
    end else begin : g_rest
      assign src_wmag = wmag_r[k];
      assign src_rem  = rem_r[k];
      assign src_dq   = dq_r[k];
      assign src_side = side_r[k];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           ge;

      // Shift the next dividend bit into the partial remainder and try the subtract.
      assign trial = {src_rem[l], src_dq[l][DATA_W-1]};
      assign diff  = trial - {1'b0, src_wmag};
      assign ge    = (trial >= {1'b0, src_wmag});

      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k+1][l] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          dq_r[k+1][l]  <= {src_dq[l][DATA_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        wmag_r[k+1] <= src_wmag;
        side_r[k+1] <= src_side;
      end
    end
  end

  assign out_q    = dq_r[DIV_STAGES];
  assign out_side = side_r[DIV_STAGES];

endmodule
`default_nettype wire

[sv/vertex_transform_perspective.sv]
// Top level of the fixed-point vertex transform with perspective divide.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_transform_perspective_macros.svh"
// The block transforms one point (x, y, z) per transfer by the 4x4 matrix held in eight
// 64-bit configuration registers, then divides the x, y and z column sums by the w column
// sum. Everything is signed Q16.16. The pipeline is 37 register stages deep: one stage for
// the twelve 32x32 products, one for the column sums, one for sign and magnitude, one for
// the overflow test, 32 for the bit-per-stage restoring divider shared by the three lanes,
// and one for saturation and sign. The block accepts a new point every cycle unless
// in_stall is high. When the output side stalls, empty stages still close up, so input
// transfers continue until every stage holds an item. A zero w gives zero coordinates
// with w_zero set; a quotient beyond the 32-bit range is clamped and sets saturated.
// The matrix must only be written while no point is in flight.
module vertex_transform_perspective (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  signed [vtp_pkg::DATA_W-1:0] in_x_in,
  input  wire  signed [vtp_pkg::DATA_W-1:0] in_y_in,
  input  wire  signed [vtp_pkg::DATA_W-1:0] in_z_in,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [vtp_pkg::DATA_W-1:0] out_x_out,
  output logic signed [vtp_pkg::DATA_W-1:0] out_y_out,
  output logic signed [vtp_pkg::DATA_W-1:0] out_z_out,
  output logic                              out_w_zero,
  output logic                              out_saturated,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [vtp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [vtp_pkg::REG_W-1:0]         cfg_data
);
  import vtp_pkg::*;

  // Matrix registers. Element [r][c] sits in register 2r + c/2, high half for odd c.
  logic [REG_W-1:0] mat_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ONE_LO;
      mat_r[1] <= '0;
      mat_r[2] <= ONE_HI;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= ONE_LO;
      mat_r[6] <= '0;
      mat_r[7] <= ONE_HI;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  function automatic logic signed [DATA_W-1:0] elem(input int r, input int c);
    logic [REG_W-1:0] reg_val;
    reg_val = mat_r[2 * r + c / 2];
    return (c % 2 == 1) ? reg_val[REG_W-1:DATA_W] : reg_val[DATA_W-1:0];
  endfunction

  // Handshake: each stage loads when it is empty or when the stage after it moves.
  logic [NSTG:1]   valid_r;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[ST_PROD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[1]) begin
        valid_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage 1: the twelve point-by-matrix products, kept at full width.
  logic signed [PROD_W-1:0] prod_r [NUM_COLS][NUM_LANES];
  logic signed [DATA_W-1:0] pt [NUM_LANES];

  assign pt[0] = in_x_in;
  assign pt[1] = in_y_in;
  assign pt[2] = in_z_in;

  always_ff @(posedge clk) begin
    if (rdy[ST_PROD]) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        for (int r = 0; r < NUM_LANES; r++) begin
          prod_r[c][r] <= PROD_W'(pt[r] * elem(r, c));
        end
      end
    end
  end

  // Stage 2: column sums, with the translation row scaled up to the product format.
  logic signed [SUM_W-1:0] sum_r [NUM_COLS];

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM]) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        sum_r[c] <= SUM_W'(prod_r[c][0]) + SUM_W'(prod_r[c][1]) + SUM_W'(prod_r[c][2])
                  + (SUM_W'(elem(NUM_ROWS - 1, c)) <<< FRAC_BITS);
      end
    end
  end

  // Stage 3: sign and magnitude. The magnitude of a column sum always fits in 64 bits.
  logic [MAG_W-1:0] mag_r [NUM_COLS];
  logic [NUM_COLS-1:0] sgn_r;
  logic                wzero3_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_MAG]) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        sgn_r[c] <= sum_r[c][SUM_W-1];
        mag_r[c] <= sum_r[c][SUM_W-1] ? MAG_W'(-sum_r[c]) : MAG_W'(sum_r[c]);
      end
      wzero3_r <= (sum_r[W_COL] == '0);
    end
  end

  // Stage 4: the scaled dividend is mag shifted up by FRAC_BITS. Its quotient has more than
  // 32 bits exactly when mag reaches w shifted up by 32 - FRAC_BITS; otherwise the upper
  // dividend bits start as the partial remainder and the lower 32 bits feed the divider.
  localparam int CMP_W = MAG_W + DATA_W - FRAC_BITS;

  logic [MAG_W-1:0]  wmag4_r;
  logic [MAG_W-1:0]  rem4_r [NUM_LANES];
  logic [DATA_W-1:0] dq4_r  [NUM_LANES];
  vtp_side_t         side4_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_PREP]) begin
      wmag4_r       <= mag_r[W_COL];
      side4_r.wzero <= wzero3_r;
      for (int l = 0; l < NUM_LANES; l++) begin
        side4_r.neg[l] <= sgn_r[l] ^ sgn_r[W_COL];
        side4_r.ovf[l] <= CMP_W'(mag_r[l]) >= (CMP_W'(mag_r[W_COL]) << (DATA_W - FRAC_BITS));
        rem4_r[l]      <= mag_r[l] >> (DATA_W - FRAC_BITS);
        dq4_r[l]       <= {mag_r[l][DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // Stages 5 to 36: the divider.
  logic [DATA_W-1:0] quo [NUM_LANES];
  vtp_side_t         div_side;

  vtp_div u_div (
    .clk      (clk),
    .en       (rdy[ST_OUT-1:ST_DIV0]),
    .in_wmag  (wmag4_r),
    .in_rem   (rem4_r),
    .in_dq    (dq4_r),
    .in_side  (side4_r),
    .out_q    (quo),
    .out_side (div_side)
  );

  // Stage 37: clamp, apply the sign, and force zeros when w was zero.
  logic [DATA_W-1:0]    res [NUM_LANES];
  logic [NUM_LANES-1:0] sat;

  always_comb begin
    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] clamped;
    for (int l = 0; l < NUM_LANES; l++) begin
      limit   = div_side.neg[l] ? NEG_LIMIT : POS_LIMIT;
      sat[l]  = !div_side.wzero && (div_side.ovf[l] || (quo[l] > limit));
      clamped = sat[l] ? limit : quo[l];
      res[l]  = div_side.wzero ? '0 : (div_side.neg[l] ? DATA_W'(-clamped) : clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      out_x_out     <= res[0];
      out_y_out     <= res[1];
      out_z_out     <= res[2];
      out_w_zero    <= div_side.wzero;
      out_saturated <= |sat;
    end
  end

  assign out_valid = valid_r[ST_OUT];

  // Summaries of the output coordinates for the checks below.
  logic out_all_zero;
  logic out_any_limit;

  assign out_all_zero  = (out_x_out == '0) && (out_y_out == '0) && (out_z_out == '0);
  assign out_any_limit = (out_x_out == POS_LIMIT) || (out_x_out == NEG_LIMIT)
                      || (out_y_out == POS_LIMIT) || (out_y_out == NEG_LIMIT)
                      || (out_z_out == POS_LIMIT) || (out_z_out == NEG_LIMIT);

  `VTP_ASSERT(a_wzero_clears, out_valid && out_w_zero |-> out_all_zero && !out_saturated, "w_zero result carries nonzero data")
  `VTP_ASSERT(a_sat_at_limit, out_valid && out_saturated |-> out_any_limit, "saturated result has no clamped lane")
  `VTP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule
`default_nettype wire
